// ===== hw/rtl/tss_pkg.sv =====
// Shared constants, reciprocal table, control word types and microprogram for the sine block.
package tss_pkg;

  // Field widths and fixed-point formats.
  localparam int ANGLE_W       = 18;
  localparam int COUNT_W       = 4;
  localparam int SUM_W         = 19;
  localparam int FRAC_BITS     = 16;
  localparam int GUARD_BITS    = 6;
  localparam int INT_FRAC      = FRAC_BITS + GUARD_BITS;
  localparam int TERM_W        = INT_FRAC + 8;
  localparam int MUL_W         = 32;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int DEF_MAX_TERMS = 10;

  // Largest term magnitude and the output limits.
  localparam logic [TERM_W-1:0] TERM_CAP = {TERM_W{1'b1}};
  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN_MAG = 262144;

  // Reciprocals floor(2^32 / k) for the small divisors of the term recurrence.
  localparam int RECIP_DEPTH = 32;
  localparam logic [63:0] RECIP_NUM = 64'h1_0000_0000;
  localparam logic [MUL_W-1:0] RECIP [RECIP_DEPTH] = '{
    32'hFFFF_FFFF,        32'hFFFF_FFFF,        32'(RECIP_NUM / 2),   32'(RECIP_NUM / 3),
    32'(RECIP_NUM / 4),   32'(RECIP_NUM / 5),   32'(RECIP_NUM / 6),   32'(RECIP_NUM / 7),
    32'(RECIP_NUM / 8),   32'(RECIP_NUM / 9),   32'(RECIP_NUM / 10),  32'(RECIP_NUM / 11),
    32'(RECIP_NUM / 12),  32'(RECIP_NUM / 13),  32'(RECIP_NUM / 14),  32'(RECIP_NUM / 15),
    32'(RECIP_NUM / 16),  32'(RECIP_NUM / 17),  32'(RECIP_NUM / 18),  32'(RECIP_NUM / 19),
    32'(RECIP_NUM / 20),  32'(RECIP_NUM / 21),  32'(RECIP_NUM / 22),  32'(RECIP_NUM / 23),
    32'(RECIP_NUM / 24),  32'(RECIP_NUM / 25),  32'(RECIP_NUM / 26),  32'(RECIP_NUM / 27),
    32'(RECIP_NUM / 28),  32'(RECIP_NUM / 29),  32'(RECIP_NUM / 30),  32'(RECIP_NUM / 31)
  };

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_ACCUM,
    OP_MAC,
    OP_RMUL,
    OP_CORR,
    OP_ABS,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_ZERO,
    JMP_LAST
  } jump_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_t;

  localparam int PC_W = 4;

  typedef struct packed {
    op_t            op;
    logic           k_odd;
    jump_t          jump;
    hold_t          hold;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    logic count_zero;
    logic last_term;
    logic out_free;
  } stat_t;

  // Microprogram addresses.
  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_ACCUM = 4'd1;
  localparam logic [PC_W-1:0] PC_MAC_E = 4'd2;
  localparam logic [PC_W-1:0] PC_MUL_E = 4'd3;
  localparam logic [PC_W-1:0] PC_COR_E = 4'd4;
  localparam logic [PC_W-1:0] PC_MAC_O = 4'd5;
  localparam logic [PC_W-1:0] PC_MUL_O = 4'd6;
  localparam logic [PC_W-1:0] PC_COR_O = 4'd7;
  localparam logic [PC_W-1:0] PC_ABS   = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT  = 4'd9;

  // Control store: one word per step.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw = '{op: OP_LOAD, k_odd: 1'b0, jump: JMP_ZERO, hold: HOLD_IN, target: PC_ABS};
    case (pc)
      PC_IDLE:  cw = '{op: OP_LOAD,  k_odd: 1'b0, jump: JMP_ZERO,   hold: HOLD_IN,
                       target: PC_ABS};
      PC_ACCUM: cw = '{op: OP_ACCUM, k_odd: 1'b0, jump: JMP_LAST,   hold: HOLD_NONE,
                       target: PC_ABS};
      PC_MAC_E: cw = '{op: OP_MAC,   k_odd: 1'b0, jump: JMP_NONE,   hold: HOLD_NONE,
                       target: PC_IDLE};
      PC_MUL_E: cw = '{op: OP_RMUL,  k_odd: 1'b0, jump: JMP_NONE,   hold: HOLD_NONE,
                       target: PC_IDLE};
      PC_COR_E: cw = '{op: OP_CORR,  k_odd: 1'b0, jump: JMP_NONE,   hold: HOLD_NONE,
                       target: PC_IDLE};
      PC_MAC_O: cw = '{op: OP_MAC,   k_odd: 1'b1, jump: JMP_NONE,   hold: HOLD_NONE,
                       target: PC_IDLE};
      PC_MUL_O: cw = '{op: OP_RMUL,  k_odd: 1'b1, jump: JMP_NONE,   hold: HOLD_NONE,
                       target: PC_IDLE};
      PC_COR_O: cw = '{op: OP_CORR,  k_odd: 1'b1, jump: JMP_ALWAYS, hold: HOLD_NONE,
                       target: PC_ACCUM};
      PC_ABS:   cw = '{op: OP_ABS,   k_odd: 1'b0, jump: JMP_NONE,   hold: HOLD_NONE,
                       target: PC_IDLE};
      PC_EMIT:  cw = '{op: OP_EMIT,  k_odd: 1'b0, jump: JMP_ALWAYS, hold: HOLD_OUT,
                       target: PC_IDLE};
      default:  cw = '{op: OP_LOAD,  k_odd: 1'b0, jump: JMP_ALWAYS, hold: HOLD_NONE,
                       target: PC_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ===== hw/rtl/tss_if.sv =====
// Valid/ready channel interfaces for the angle input and the sine result.
interface tss_angle_if import tss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;
  logic [COUNT_W-1:0] term_count;

  modport source (output valid, angle, term_count, input ready);
  modport sink (input valid, angle, term_count, output ready);
endinterface

interface tss_sine_if import tss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sine_sum;

  modport source (output valid, sine_sum, input ready);
  modport sink (input valid, sine_sum, output ready);
endinterface

// ===== hw/rtl/tss_sequencer.sv =====
// Step counter, control store lookup and jump logic of the sine sequencer.
module tss_sequencer import tss_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  input  logic  in_valid,
  output ctrl_t cw,
  output logic  fire,
  output logic  in_ready
);

  logic [PC_W-1:0] pc;
  logic            taken;

  // Current control word.
  assign cw = ucode(pc);
  assign in_ready = (cw.hold == HOLD_IN);

  // A step executes unless it waits on a channel.
  always_comb begin
    case (cw.hold)
      HOLD_NONE: fire = 1'b1;
      HOLD_IN:   fire = in_valid;
      HOLD_OUT:  fire = stat.out_free;
      default:   fire = 1'b1;
    endcase
  end

  // Jump condition.
  always_comb begin
    case (cw.jump)
      JMP_NONE:   taken = 1'b0;
      JMP_ALWAYS: taken = 1'b1;
      JMP_ZERO:   taken = stat.count_zero;
      JMP_LAST:   taken = stat.last_term;
      default:    taken = 1'b0;
    endcase
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else if (fire) begin
      pc <= taken ? cw.target : pc + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/tss_datapath.sv =====
// Shared multiplier, term and accumulator registers, and output register of the sine block.
module tss_datapath import tss_pkg::*; #(
  parameter int MAX_TERMS = DEF_MAX_TERMS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_t                   cw,
  input  logic                    fire,
  input  logic [ANGLE_W-1:0]      angle,
  input  logic [COUNT_W-1:0]      term_count,
  input  logic                    out_ready,
  output stat_t                   stat,
  output logic                    out_valid,
  output logic signed [SUM_W-1:0] sine_sum
);

  localparam int NW    = $clog2(MAX_TERMS + 1);
  localparam int KW    = NW + 1;
  localparam int ACC_W = TERM_W + 1 + $clog2(MAX_TERMS + 1);
  localparam int CMP_W = (COUNT_W > NW ? COUNT_W : NW) + 1;
  localparam int REM_W = MUL_W + 5;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (GUARD_BITS - 1);

  logic [ANGLE_W-1:0]      x;
  logic [NW-1:0]           n;
  logic [NW-1:0]           i;
  logic [TERM_W-1:0]       term;
  logic [PROD_W-1:0]       prod;
  logic [MUL_W-1:0]        y;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0]        mag;
  logic                    neg;

  logic [KW-1:0]           k;
  logic [4:0]              k5;
  logic [MUL_W-1:0]        y_now;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic [CMP_W-1:0]        count_ext;
  logic [NW-1:0]           count_cap;
  logic [MUL_W-1:0]        q0;
  logic [REM_W-1:0]        rem;
  logic [MUL_W:0]          q_fix;
  logic signed [ACC_W-1:0] term_s;
  logic [ACC_W-1:0]        rnd;
  logic signed [SUM_W-1:0] sum_sat;

  // Divisor of the current step: 2i for the even half, 2i+1 for the odd half.
  assign k  = {i, cw.k_odd};
  assign k5 = 5'(k);

  // Shared multiplier: term times angle, or scaled product times reciprocal.
  assign y_now = MUL_W'(prod >> FRAC_BITS);
  assign mul_a = (cw.op == OP_RMUL) ? y_now : MUL_W'(term);
  assign mul_b = (cw.op == OP_RMUL) ? RECIP[k5] : MUL_W'(x);
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Count limited to the number of terms the block supports.
  assign count_ext = CMP_W'(term_count);
  assign count_cap = (count_ext > CMP_W'(MAX_TERMS)) ? NW'(MAX_TERMS) : NW'(count_ext);

  // Quotient estimate is low by at most one; the remainder corrects it.
  assign q0    = prod[PROD_W-1:MUL_W];
  assign rem   = REM_W'(y) - REM_W'(q0) * REM_W'(k5);
  assign q_fix = (rem >= REM_W'(k5)) ? (MUL_W + 1)'(q0) + 1'b1 : (MUL_W + 1)'(q0);

  assign term_s = ACC_W'(term);

  // Round the magnitude to the output format and saturate with its sign.
  assign rnd = (mag + HALF) >> GUARD_BITS;
  always_comb begin
    if (neg) begin
      sum_sat = (rnd > ACC_W'(OUT_MIN_MAG)) ? SUM_W'(-OUT_MIN_MAG) : SUM_W'(-rnd);
    end else begin
      sum_sat = (rnd > ACC_W'(OUT_MAX)) ? SUM_W'(OUT_MAX) : SUM_W'(rnd);
    end
  end

  // Conditions for the sequencer.
  assign stat.count_zero = (term_count == '0);
  assign stat.last_term  = ((NW + 1)'(i) + 1'b1 == (NW + 1)'(n));
  assign stat.out_free   = !out_valid || out_ready;

  // Working registers, updated by the operation of the step that fires.
  always_ff @(posedge clk) begin
    if (fire) begin
      case (cw.op)
        OP_LOAD: begin
          x    <= angle;
          n    <= count_cap;
          i    <= '0;
          acc  <= '0;
          term <= TERM_W'({angle, GUARD_BITS'(0)});
        end
        OP_ACCUM: begin
          acc <= i[0] ? acc - term_s : acc + term_s;
          i   <= i + 1'b1;
        end
        OP_MAC: begin
          prod <= mul_p + (PROD_W'(k) << (FRAC_BITS - 1));
        end
        OP_RMUL: begin
          y    <= y_now;
          prod <= mul_p;
        end
        OP_CORR: begin
          term <= (q_fix > (MUL_W + 1)'(TERM_CAP)) ? TERM_CAP : TERM_W'(q_fix);
        end
        OP_ABS: begin
          neg <= acc[ACC_W-1];
          mag <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        end
        OP_EMIT: begin
          sine_sum <= sum_sat;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && cw.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/taylor_series_sine.sv =====
// Each further term costs six steps, four of them on the one shared 32x32 multiplier, plus one accumulate step.
// An item is taken only once the last one has reached the result register; a new item is taken while a result waits.
// The result register holds one beat; a stalled result delays only the final step.
// Reset is synchronous and active high; it returns the sequencer to idle and drops result valid.
// There is no stored state that survives between items.
module taylor_series_sine import tss_pkg::*; #(
  parameter int MAX_TERMS = DEF_MAX_TERMS
) (
  input logic       clk,
  input logic       rst,
  tss_angle_if.sink operand,
  tss_sine_if.source result
);

  ctrl_t cw;
  stat_t stat;
  logic  fire;

  // Microprogram control.
  tss_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .in_valid (operand.valid),
    .cw       (cw),
    .fire     (fire),
    .in_ready (operand.ready)
  );

  // Arithmetic and result register.
  tss_datapath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cw         (cw),
    .fire       (fire),
    .angle      (operand.angle),
    .term_count (operand.term_count),
    .out_ready  (result.ready),
    .stat       (stat),
    .out_valid  (result.valid),
    .sine_sum   (result.sine_sum)
  );

endmodule

// ===== hw/rtl/tss_checker.sv =====
// Port-level checks of the sine block and their binding to the top level.
module tss_checker import tss_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SUM_W-1:0] sine_sum
);

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sine_sum))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // After taking an item the block is busy computing it.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

endmodule

bind taylor_series_sine tss_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (operand.valid),
  .in_ready  (operand.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .sine_sum  (result.sine_sum)
);

// ===== tb/sv/taylor_series_sine_tb.sv =====
// Self-checking testbench for the partial Maclaurin sine block with a bit-exact predictor.
module taylor_series_sine_tb;
  import tss_pkg::*;

  localparam int MAX_TERMS   = DEF_MAX_TERMS;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int RANDOM_ITEMS = 780;
  localparam int N_DIRECTED   = 23;

  localparam logic [ANGLE_W-1:0] ANGLE_THREE = 18'd196608;
  localparam logic [ANGLE_W-1:0] ANGLE_TOP   = {ANGLE_W{1'b1}};

  // One row of the directed table; known rows carry a hand-derived sum.
  typedef struct packed {
    logic [ANGLE_W-1:0]      angle;
    logic [COUNT_W-1:0]      count;
    logic                    known;
    logic signed [SUM_W-1:0] sum;
  } sine_case_t;

  sine_case_t directed_cases [N_DIRECTED] = '{
    '{18'd0,      4'd0,  1'b1, 19'sd0},
    '{ANGLE_THREE, 4'd0, 1'b1, 19'sd0},
    '{18'd0,      4'd10, 1'b1, 19'sd0},
    '{18'd0,      4'd15, 1'b1, 19'sd0},
    '{ANGLE_TOP,  4'd0,  1'b1, 19'sd0},
    '{ANGLE_THREE, 4'd1, 1'b1, 19'sd196608},
    '{ANGLE_TOP,  4'd1,  1'b1, 19'sd262143},
    '{18'd1,      4'd1,  1'b1, 19'sd1},
    '{ANGLE_THREE, 4'd10, 1'b0, 19'sd0},
    '{ANGLE_THREE, 4'd15, 1'b0, 19'sd0},
    '{ANGLE_TOP,  4'd10, 1'b0, 19'sd0},
    '{ANGLE_TOP,  4'd15, 1'b0, 19'sd0},
    '{ANGLE_TOP,  4'd2,  1'b0, 19'sd0},
    '{18'd1,      4'd10, 1'b0, 19'sd0},
    '{18'd102944, 4'd10, 1'b0, 19'sd0},
    '{18'd65536,  4'd2,  1'b0, 19'sd0},
    '{18'd65536,  4'd4,  1'b0, 19'sd0},
    '{18'd65536,  4'd6,  1'b0, 19'sd0},
    '{18'd65536,  4'd8,  1'b0, 19'sd0},
    '{18'd131072, 4'd3,  1'b0, 19'sd0},
    '{18'd131072, 4'd5,  1'b0, 19'sd0},
    '{18'd131072, 4'd7,  1'b0, 19'sd0},
    '{18'd131072, 4'd9,  1'b0, 19'sd0}
  };

  logic clk;
  logic rst;

  tss_angle_if operand_ch ();
  tss_sine_if  result_ch ();

  taylor_series_sine #(.MAX_TERMS(MAX_TERMS)) uut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_ch),
    .result  (result_ch)
  );

  logic signed [SUM_W-1:0] sine_expected [$];
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Free-running clock, period 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One recurrence step: round(t * x / (k * 2^FRAC_BITS)), halves up, capped.
  function automatic logic [63:0] scaled_term_step(input logic [63:0] t, input logic [63:0] x,
                                                   input logic [63:0] k);
    logic [63:0] prod;
    logic [63:0] div;
    logic [63:0] quot;
    prod = t * x;
    div = k << FRAC_BITS;
    quot = (prod + (div >> 1)) / div;
    if (quot > 64'(TERM_CAP)) quot = 64'(TERM_CAP);
    return quot;
  endfunction

  // Partial sine sum with guard bits, final rounding away from zero and saturation.
  function automatic logic signed [SUM_W-1:0] sine_partial_sum(input logic [ANGLE_W-1:0] angle,
                                                               input logic [COUNT_W-1:0] count);
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] term;
    logic [63:0] mag;
    longint acc;
    longint r;
    int i;
    x = 64'(angle);
    n = 64'(count);
    if (n > 64'(MAX_TERMS)) n = 64'(MAX_TERMS);
    term = x << GUARD_BITS;
    if (term > 64'(TERM_CAP)) term = 64'(TERM_CAP);
    acc = 0;
    for (i = 0; i < int'(n); i++) begin
      if (i > 0) begin
        term = scaled_term_step(term, x, 64'(2 * i));
        term = scaled_term_step(term, x, 64'(2 * i + 1));
      end
      if (i % 2 == 0) acc = acc + longint'(term);
      else acc = acc - longint'(term);
    end
    if (acc >= 0) begin
      mag = (64'(acc) + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
      r = longint'(mag);
    end else begin
      mag = (64'(-acc) + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
      r = -longint'(mag);
    end
    if (r > longint'(OUT_MAX)) r = longint'(OUT_MAX);
    if (r < -longint'(OUT_MIN_MAG)) r = -longint'(OUT_MIN_MAG);
    return r[SUM_W-1:0];
  endfunction

  task automatic report_failure(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  // Drive one operand beat after a random gap and wait until it is taken.
  task automatic send_operand(input logic [ANGLE_W-1:0] angle, input logic [COUNT_W-1:0] count,
                              input logic known, input logic signed [SUM_W-1:0] known_sum);
    while ($urandom_range(99) < send_idle_pct) begin
      operand_ch.valid = 1'b0;
      @(negedge clk);
    end
    operand_ch.valid = 1'b1;
    operand_ch.angle = angle;
    operand_ch.term_count = count;
    do @(posedge clk); while (operand_ch.ready !== 1'b1);
    if (known) sine_expected.push_back(known_sum);
    else sine_expected.push_back(sine_partial_sum(angle, count));
    @(negedge clk);
  endtask

  // Random operands: mostly in the intended range, some beyond it.
  task automatic send_random_operands(input int items);
    logic [ANGLE_W-1:0] angle;
    logic [COUNT_W-1:0] count;
    int i;
    for (i = 0; i < items; i++) begin
      if ($urandom_range(99) < 85) angle = ANGLE_W'($urandom_range(196608, 0));
      else angle = ANGLE_W'($urandom_range(262143, 0));
      if ($urandom_range(99) < 85) count = COUNT_W'($urandom_range(MAX_TERMS, 0));
      else count = COUNT_W'($urandom_range(15, MAX_TERMS + 1));
      send_operand(angle, count, 1'b0, '0);
    end
  endtask

  // Result ready is chosen at each falling edge from the current idle rate.
  initial result_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (rst) result_ch.ready = 1'b0;
    else result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Each result beat is compared with the oldest pending sum.
  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (sine_expected.size() == 0) begin
        report_failure($sformatf("unexpected result %0d", result_ch.sine_sum));
      end else begin
        if (result_ch.sine_sum !== sine_expected[0])
          report_failure($sformatf("sine_sum got %0d want %0d",
                                   result_ch.sine_sum, sine_expected[0]));
        void'(sine_expected.pop_front());
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Main sequence: reset, directed table, three random phases, drain.
  initial begin
    int i;
    rst = 1'b1;
    operand_ch.valid = 1'b0;
    operand_ch.angle = '0;
    operand_ch.term_count = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 17;
    recv_idle_pct = 79;
    for (i = 0; i < N_DIRECTED; i++)
      send_operand(directed_cases[i].angle, directed_cases[i].count,
                   directed_cases[i].known, directed_cases[i].sum);
    send_random_operands(RANDOM_ITEMS / 3);

    send_idle_pct = 79;
    recv_idle_pct = 17;
    send_random_operands(RANDOM_ITEMS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_operands(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    operand_ch.valid = 1'b0;

    while (sine_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
